FILE: rtl/ilie_pkg.sv
// ilie_pkg: shared types and default sizes for the indexed list store
// no dependencies; used by the command interface and the top level
package ilie_pkg;

    // default store geometry
    localparam int DEPTH_DEFAULT       = 1024;
    localparam int VALUE_WIDTH_DEFAULT = 32;

    // operation codes carried in a command transaction
    typedef enum logic [1:0] {
        KIND_INSERT = 2'd0,
        KIND_ERASE  = 2'd1,
        KIND_GET    = 2'd2,
        KIND_SET    = 2'd3
    } kind_t;

endpackage

FILE: rtl/ilie_cmd_if.sv
// ilie_cmd_if: command channel (valid/ready) of the indexed list store
// depends on ilie_pkg for the operation code type
interface ilie_cmd_if #(
    parameter int POS_W       = 11,
    parameter int VALUE_WIDTH = ilie_pkg::VALUE_WIDTH_DEFAULT
);
    logic                          valid;
    logic                          ready;
    ilie_pkg::kind_t               kind;
    logic [POS_W-1:0]              position;
    logic [POS_W-1:0]              count;
    logic signed [VALUE_WIDTH-1:0] value;

    modport source (output valid, kind, position, count, value, input ready);
    modport sink   (input valid, kind, position, count, value, output ready);
endinterface

FILE: rtl/ilie_rsp_if.sv
// ilie_rsp_if: response channel (valid/ready) of the indexed list store
// no dependencies
interface ilie_rsp_if #(
    parameter int POS_W       = 11,
    parameter int VALUE_WIDTH = 32
);
    logic                          valid;
    logic                          ready;
    logic signed [VALUE_WIDTH-1:0] read_data;
    logic [POS_W-1:0]              length;
    logic [POS_W:0]                reserved_capacity;
    logic                          error;

    modport source (output valid, read_data, length, reserved_capacity, error, input ready);
    modport sink   (input valid, read_data, length, reserved_capacity, error, output ready);
endinterface

FILE: rtl/indexed_list_insert_erase.sv
// indexed_list_insert_erase: ordered list store with insert, erase, get and set
// depends on ilie_pkg, ilie_cmd_if and ilie_rsp_if
//
//   channel  direction  handshake    payload
//   cmd      in         valid/ready  kind, position, count, value
//   rsp      out        valid/ready  read_data, length, reserved_capacity, error
//
// One command at a time; cmd.ready is high only while the sequencer is idle.
// Insert and erase move the entries behind the position in ST_SHIFT, then pass ST_COMMIT
// and ST_DONE; get, set and refused commands go straight to ST_DONE. One memory entry
// moves per cycle through the single read and single write port of the entry memory.
// A finished response waits in the output register until rsp.ready; no reset sweep,
// the store starts empty and only written entries are read.
module indexed_list_insert_erase #(
    parameter int DEPTH       = ilie_pkg::DEPTH_DEFAULT,
    parameter int VALUE_WIDTH = ilie_pkg::VALUE_WIDTH_DEFAULT
) (
    input  logic            clk,
    input  logic            rst_n,
    ilie_cmd_if.sink        cmd,
    ilie_rsp_if.source      rsp
);

    localparam int POS_W  = $clog2(DEPTH + 1);
    localparam int CAP_W  = POS_W + 1;
    localparam int ADDR_W = $clog2(DEPTH);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SHIFT  = 4'b0010,
        ST_COMMIT = 4'b0100,
        ST_DONE   = 4'b1000
    } state_t;

    // entry memory, one write and one registered read port
    logic signed [VALUE_WIDTH-1:0] mem [DEPTH];
    logic signed [VALUE_WIDTH-1:0] rdata_reg;
    logic                          mem_we;
    logic [ADDR_W-1:0]             mem_waddr;
    logic signed [VALUE_WIDTH-1:0] mem_wdata;
    logic                          mem_re;
    logic [ADDR_W-1:0]             mem_raddr;

    // sequencer and list state
    state_t                        state_reg, state_next;
    ilie_pkg::kind_t               kind_reg, kind_next;
    logic [POS_W-1:0]              pos_reg, pos_next;
    logic [POS_W-1:0]              cnt_reg, cnt_next;
    logic signed [VALUE_WIDTH-1:0] val_reg, val_next;
    logic                          err_reg, err_next;
    logic [ADDR_W-1:0]             src_reg, src_next;
    logic [ADDR_W-1:0]             dst_reg, dst_next;
    logic [ADDR_W-1:0]             ofs_reg, ofs_next;
    logic                          down_reg, down_next;
    logic [POS_W-1:0]              left_reg, left_next;
    logic                          pend_reg, pend_next;
    logic [POS_W-1:0]              count_reg, count_next;
    logic [CAP_W-1:0]              cap_reg, cap_next;

    // output register
    logic                          out_valid_reg, out_valid_next;
    logic signed [VALUE_WIDTH-1:0] out_data_reg, out_data_next;
    logic [POS_W-1:0]              out_len_reg, out_len_next;
    logic [CAP_W-1:0]              out_cap_reg, out_cap_next;
    logic                          out_err_reg, out_err_next;

    // accept-time checks
    logic                          accept;
    logic [POS_W-1:0]              room;
    logic                          past_end;
    logic                          full;
    logic [POS_W-1:0]              count_inc;

    assign accept    = cmd.valid && cmd.ready;
    assign room      = count_reg - cmd.position;
    assign past_end  = cmd.position > count_reg;
    assign full      = count_reg == POS_W'(DEPTH);
    assign count_inc = count_reg + POS_W'(1);

    assign cmd.ready             = state_reg == ST_IDLE;
    assign rsp.valid             = out_valid_reg;
    assign rsp.read_data         = out_data_reg;
    assign rsp.length            = out_len_reg;
    assign rsp.reserved_capacity = out_cap_reg;
    assign rsp.error             = out_err_reg;

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        kind_next      = kind_reg;
        pos_next       = pos_reg;
        cnt_next       = cnt_reg;
        val_next       = val_reg;
        err_next       = err_reg;
        src_next       = src_reg;
        dst_next       = dst_reg;
        ofs_next       = ofs_reg;
        down_next      = down_reg;
        left_next      = left_reg;
        pend_next      = pend_reg;
        count_next     = count_reg;
        cap_next       = cap_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_len_next   = out_len_reg;
        out_cap_next   = out_cap_reg;
        out_err_next   = out_err_reg;
        mem_we         = 1'b0;
        mem_waddr      = pos_reg[ADDR_W-1:0];
        mem_wdata      = val_reg;
        mem_re         = 1'b0;
        mem_raddr      = src_reg;

        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    kind_next = cmd.kind;
                    pos_next  = cmd.position;
                    cnt_next  = cmd.count;
                    val_next  = cmd.value;
                    pend_next = 1'b0;
                    unique case (cmd.kind)
                        ilie_pkg::KIND_INSERT:
                        begin
                            err_next   = past_end || full;
                            left_next  = room;
                            down_next  = 1'b1;
                            src_next   = ADDR_W'(count_reg - POS_W'(1));
                            ofs_next   = ADDR_W'(1);
                            state_next = (past_end || full) ? ST_DONE : ST_SHIFT;
                        end
                        ilie_pkg::KIND_ERASE:
                        begin
                            err_next   = past_end || (cmd.count > room);
                            left_next  = (cmd.count == '0) ? '0 : room - cmd.count;
                            down_next  = 1'b0;
                            src_next   = ADDR_W'(cmd.position + cmd.count);
                            ofs_next   = ADDR_W'(-cmd.count);
                            state_next = (past_end || (cmd.count > room)) ? ST_DONE
                                                                          : ST_SHIFT;
                        end
                        ilie_pkg::KIND_GET:
                        begin
                            err_next   = !(cmd.position < count_reg);
                            mem_re     = cmd.position < count_reg;
                            mem_raddr  = cmd.position[ADDR_W-1:0];
                            state_next = ST_DONE;
                        end
                        ilie_pkg::KIND_SET:
                        begin
                            err_next   = !(cmd.position < count_reg);
                            mem_we     = cmd.position < count_reg;
                            mem_waddr  = cmd.position[ADDR_W-1:0];
                            mem_wdata  = cmd.value;
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end

            ST_SHIFT:
            begin
                // write back the entry fetched last cycle
                mem_we    = pend_reg;
                mem_waddr = dst_reg;
                mem_wdata = rdata_reg;
                if (left_reg != '0)
                begin
                    // fetch the next entry and note where it lands
                    mem_re    = 1'b1;
                    mem_raddr = src_reg;
                    dst_next  = src_reg + ofs_reg;
                    src_next  = down_reg ? src_reg - ADDR_W'(1) : src_reg + ADDR_W'(1);
                    left_next = left_reg - POS_W'(1);
                    pend_next = 1'b1;
                end
                else
                begin
                    pend_next  = 1'b0;
                    state_next = ST_COMMIT;
                end
            end

            ST_COMMIT:
            begin
                if (kind_reg == ilie_pkg::KIND_INSERT)
                begin
                    // new value into the opened slot, grow capacity past the length
                    mem_we     = 1'b1;
                    mem_waddr  = pos_reg[ADDR_W-1:0];
                    mem_wdata  = val_reg;
                    count_next = count_inc;
                    if ({1'b0, count_inc} == cap_reg)
                    begin
                        cap_next = cap_reg << 1;
                    end
                end
                else
                begin
                    count_next = count_reg - cnt_reg;
                end
                state_next = ST_DONE;
            end

            ST_DONE:
            begin
                // load the response once the output register is free
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = (kind_reg == ilie_pkg::KIND_GET && !err_reg)
                                     ? rdata_reg : '0;
                    out_len_next   = count_reg;
                    out_cap_next   = cap_reg;
                    out_err_next   = err_reg;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // entry memory
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= mem[mem_raddr];
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            cap_reg       <= CAP_W'(1);
            out_valid_reg <= 1'b0;
            pend_reg      <= 1'b0;
            left_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            cap_reg       <= cap_next;
            out_valid_reg <= out_valid_next;
            pend_reg      <= pend_next;
            left_reg      <= left_next;
        end
    end

    // payload and working registers
    always_ff @(posedge clk)
    begin
        kind_reg     <= kind_next;
        pos_reg      <= pos_next;
        cnt_reg      <= cnt_next;
        val_reg      <= val_next;
        err_reg      <= err_next;
        src_reg      <= src_next;
        dst_reg      <= dst_next;
        ofs_reg      <= ofs_next;
        down_reg     <= down_next;
        out_data_reg <= out_data_next;
        out_len_reg  <= out_len_next;
        out_cap_reg  <= out_cap_next;
        out_err_reg  <= out_err_next;
    end

endmodule
